FILE: rtl/core/led_intensity_frame_builder_defines.svh
// assertion macros for the led intensity frame builder
// no dependencies; included by the files that assert
`ifndef LED_INTENSITY_FRAME_BUILDER_DEFINES_SVH
`define LED_INTENSITY_FRAME_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
`define LIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lif assertion failed");
`define LIF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lif assertion failed");
`else
`define LIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LIF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/lif_pkg.sv
// types, codes and the percent to grayscale table of the frame builder
// no dependencies
package lif_pkg;

  localparam int LED_COUNT     = 6;
  localparam int CHANNEL_COUNT = 24;
  localparam int GS_BITS       = 12;
  localparam int GS_MAX        = 4095;
  localparam int PCT_FULL      = 100;
  localparam int FRAME_BYTES   = (CHANNEL_COUNT * GS_BITS + 7) / 8;

  localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_NUM_W = ($clog2(LED_COUNT + 1) > 3) ? $clog2(LED_COUNT + 1) : 3;
  localparam int CH_CNT_W  = $clog2(CHANNEL_COUNT + 1);
  localparam int IDX_W     = (CH_CNT_W > LED_W) ? CH_CNT_W : LED_W;
  localparam int BYTE_W    = $clog2(FRAME_BYTES);

  localparam logic [1:0] ACT_SET_ONE = 2'd0;
  localparam logic [1:0] ACT_SET_ALL = 2'd1;
  localparam logic [1:0] ACT_ENABLE  = 2'd2;
  localparam logic [1:0] ACT_DISABLE = 2'd3;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_PCT = 2'd1;
  localparam logic [1:0] STATUS_NUM = 2'd2;

  // bits held in the byte buffer
  localparam logic [1:0] FILL_0 = 2'd0;
  localparam logic [1:0] FILL_4 = 2'd1;
  localparam logic [1:0] FILL_8 = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] led_number;
    logic [6:0] percent;
  } lif_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;
  } lif_out_t;

  typedef struct packed {
    logic start;
    logic advance;
  } lif_gb_ctrl_t;

  typedef struct packed {
    logic [7:0]          frame_byte;
    logic                last;
    logic                ch_valid;
    logic [CH_CNT_W-1:0] ch;
  } lif_gb_stat_t;

  typedef logic [GS_BITS-1:0] lif_lvl_tbl_t [0:127];

  function automatic lif_lvl_tbl_t lif_build_tbl();
    lif_lvl_tbl_t t;
    int           c;
    for (int i = 0; i < 128; i++) begin
      c = (i > PCT_FULL) ? PCT_FULL : i;
      t[i] = GS_BITS'((c * GS_MAX) / PCT_FULL);
    end
    return t;
  endfunction

  localparam lif_lvl_tbl_t LEVEL_TBL = lif_build_tbl();

endpackage

FILE: rtl/core/lif_gearbox.sv
// byte serializer: packs 12-bit channel levels into frame bytes, one byte a cycle while ctrl.advance is high
// depends on lif_pkg and the assertion macro header
`include "led_intensity_frame_builder_defines.svh"

module lif_gearbox (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lif_pkg::lif_gb_ctrl_t            ctrl,
  input  logic [lif_pkg::GS_BITS-1:0]      level,
  output lif_pkg::lif_gb_stat_t            stat
);
  import lif_pkg::*;

  logic [CH_CNT_W-1:0] ch_left_r, ch_left_nxt;
  logic [1:0]          fill_r, fill_nxt;
  logic [7:0]          buf_r, buf_nxt;
  logic [BYTE_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [19:0]         merged;
  logic                consume;
  logic                last;

  always_comb begin
    consume = 1'b1;
    unique case (fill_r)
      FILL_0:  merged = {level, 8'd0};
      FILL_4:  merged = {buf_r[7:4], level, 4'd0};
      default: begin
        merged  = {buf_r, 12'd0};
        consume = 1'b0;
      end
    endcase
  end

  assign last = (byte_cnt_r == BYTE_W'(FRAME_BYTES - 1));

  always_comb begin
    ch_left_nxt  = ch_left_r;
    fill_nxt     = fill_r;
    buf_nxt      = buf_r;
    byte_cnt_nxt = byte_cnt_r;
    priority if (ctrl.start) begin
      ch_left_nxt  = CH_CNT_W'(CHANNEL_COUNT);
      fill_nxt     = FILL_0;
      buf_nxt      = 8'd0;
      byte_cnt_nxt = '0;
    end else if (ctrl.advance) begin
      buf_nxt      = merged[11:4];
      byte_cnt_nxt = byte_cnt_r + 1'b1;
      if (consume && ch_left_r != '0) begin
        ch_left_nxt = ch_left_r - 1'b1;
      end
      unique case (fill_r)
        FILL_0:  fill_nxt = FILL_4;
        FILL_4:  fill_nxt = FILL_8;
        default: fill_nxt = FILL_0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_left_r  <= '0;
      fill_r     <= FILL_0;
      byte_cnt_r <= '0;
    end else begin
      ch_left_r  <= ch_left_nxt;
      fill_r     <= fill_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign stat.frame_byte = merged[19:12];
  assign stat.last       = last;
  assign stat.ch_valid   = consume && (ch_left_r != '0);
  assign stat.ch         = CH_CNT_W'(ch_left_r - 1'b1);

  `LIF_ASSERT_IMP(a_last_drained, clk, rst_n, ctrl.advance && last, ch_left_r == '0)
  `LIF_ASSERT_NXT(a_start_load, clk, rst_n, ctrl.start, fill_r == FILL_0 && byte_cnt_r == '0)
  `LIF_ASSERT_IMP(a_full_buf_no_ch, clk, rst_n, fill_r == FILL_8, !stat.ch_valid)

endmodule

FILE: rtl/core/led_intensity_frame_builder.sv
// top level of the led intensity frame builder: command decode, led state, output word
// depends on lif_pkg, lif_gearbox and the assertion macro header
//
//   channel  dir  handshake             word
//   in_      in   in_valid / in_stall   lif_in_t  action, led_number, percent
//   out_     out  out_valid / out_stall lif_out_t frame_byte, last_byte, status
//
// a valid command gives FRAME_BYTES words, one a cycle without stalls, set by the
// byte serializer; an error gives one word. a command is taken the cycle after the
// last word of the previous one is loaded. reset clears all led state. out_stall
// holds the output word and pauses the frame.
`include "led_intensity_frame_builder_defines.svh"

module led_intensity_frame_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lif_pkg::lif_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output lif_pkg::lif_out_t out_word
);
  import lif_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FRAME = 3'b010,
    ST_ERR   = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     err_r, err_nxt;
  logic [6:0]     percent_r [LED_COUNT];
  logic [6:0]     percent_nxt [LED_COUNT];
  logic           enabled_r [LED_COUNT];
  logic           enabled_nxt [LED_COUNT];
  logic           out_valid_r, out_valid_nxt;
  lif_out_t       out_r, out_nxt;

  lif_gb_ctrl_t   gb_ctrl;
  lif_gb_stat_t   gb_stat;
  logic [GS_BITS-1:0] level;
  logic [IDX_W-1:0]   ch_ext;

  logic                 accept;
  logic                 slot_free;
  logic                 adv;
  logic [LED_NUM_W-1:0] num_ext;
  logic                 num_ok;
  logic                 pct_bad;
  logic [1:0]           code;
  logic [LED_W-1:0]     idx;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign adv       = (state_r == ST_FRAME) && slot_free;

  assign num_ext = LED_NUM_W'(in_word.led_number);
  assign num_ok  = (num_ext != '0) && (num_ext <= LED_NUM_W'(LED_COUNT));
  assign pct_bad = (in_word.percent > 7'(PCT_FULL));
  assign idx     = LED_W'(num_ext - 1'b1);

  always_comb begin
    code = STATUS_OK;
    unique case (in_word.action)
      ACT_SET_ONE: begin
        if (pct_bad) begin
          code = STATUS_PCT;
        end else if (!num_ok) begin
          code = STATUS_NUM;
        end
      end
      ACT_SET_ALL: begin
        if (pct_bad) begin
          code = STATUS_PCT;
        end
      end
      default: begin
        if (!num_ok) begin
          code = STATUS_NUM;
        end
      end
    endcase
  end

  // level of the channel the serializer asks for
  assign ch_ext = IDX_W'(gb_stat.ch);
  always_comb begin
    level = '0;
    if (gb_stat.ch_valid && ch_ext < IDX_W'(LED_COUNT)) begin
      if (enabled_r[ch_ext[LED_W-1:0]]) begin
        level = LEVEL_TBL[percent_r[ch_ext[LED_W-1:0]]];
      end
    end
  end

  assign gb_ctrl.start   = accept && (code == STATUS_OK);
  assign gb_ctrl.advance = adv;

  lif_gearbox u_gearbox (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (gb_ctrl),
    .level (level),
    .stat  (gb_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    percent_nxt   = percent_r;
    enabled_nxt   = enabled_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (code != STATUS_OK) begin
            err_nxt   = code;
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_FRAME;
            unique case (in_word.action)
              ACT_SET_ONE: begin
                percent_nxt[idx] = in_word.percent;
                enabled_nxt[idx] = (in_word.percent != 7'd0);
              end
              ACT_SET_ALL: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                  percent_nxt[i] = in_word.percent;
                  enabled_nxt[i] = (in_word.percent != 7'd0);
                end
              end
              ACT_ENABLE:  enabled_nxt[idx] = 1'b1;
              default:     enabled_nxt[idx] = 1'b0;
            endcase
          end
        end
      end
      ST_FRAME: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.frame_byte = gb_stat.frame_byte;
          out_nxt.last_byte  = gb_stat.last;
          out_nxt.status     = STATUS_OK;
          if (gb_stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.frame_byte = 8'd0;
          out_nxt.last_byte  = 1'b1;
          out_nxt.status     = err_r;
          state_nxt          = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        percent_r[i] <= 7'd0;
        enabled_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      percent_r   <= percent_nxt;
      enabled_r   <= enabled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `LIF_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, in_stall)
  `LIF_ASSERT_IMP(a_err_word, clk, rst_n, out_valid && out_word.status != STATUS_OK,
                  out_word.last_byte && out_word.frame_byte == 8'd0)
  `LIF_ASSERT_NXT(a_last_idle, clk, rst_n, adv && gb_stat.last,
                  !in_stall && out_valid && out_word.last_byte)

endmodule
